/* sv/ffoa_pkg.sv */
`default_nettype none

package ffoa_pkg;

	// Fixed payload widths of the channels
	localparam int unsigned SIZE_W  = 11;
	localparam int unsigned OWNER_W = 10;
	localparam int unsigned START_W = 10;
	localparam int unsigned COUNT_W = 11;

	// Request operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Size register reset value and saturation limit of the freed count
	localparam logic [SIZE_W-1:0]  MEM_SIZE_RST = 11'd1024;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'h7FF;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear;
		logic capture;
		logic scan;
		logic fill;
		logic load_out;
	} ffoa_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_done;
		logic scan_done;
		logic hit;
		logic fill_done;
	} ffoa_sts_t;

endpackage

`default_nettype wire

/* sv/ffoa_if.sv */
`default_nettype none

interface ffoa_req_if import ffoa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [SIZE_W-1:0]  request_size;
	logic [OWNER_W-1:0] owner;

	modport source (output valid, output command, output request_size, output owner,
		input ready);
	modport sink (input valid, input command, input request_size, input owner,
		output ready);
endinterface

interface ffoa_rsp_if import ffoa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [START_W-1:0] start_index;
	logic [COUNT_W-1:0] freed_count;

	modport source (output valid, output found, output start_index, output freed_count,
		input ready);
	modport sink (input valid, input found, input start_index, input freed_count,
		output ready);
endinterface

`default_nettype wire

/* sv/ffoa_ctrl.sv */
`default_nettype none

module ffoa_ctrl import ffoa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	input  wire ffoa_sts_t sts,
	output ffoa_cmd_t      cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_FILL  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	// Sequence clear, capture, scan, fill and result hand-over
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = sts.hit ? ST_FILL : ST_DONE;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Hold state and the output slot flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* sv/ffoa_dp.sv */
`default_nettype none

module ffoa_dp import ffoa_pkg::*; #(
	parameter int unsigned CELLS      = 1024,
	parameter int unsigned OWNER_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ffoa_cmd_t          cmd,
	output ffoa_sts_t               sts,
	input  wire logic               cfg_we,
	input  wire logic [SIZE_W-1:0]  cfg_wdata,
	input  wire logic               command,
	input  wire logic [SIZE_W-1:0]  request_size,
	input  wire logic [OWNER_W-1:0] owner,
	output logic                    found,
	output logic [START_W-1:0]      start_index,
	output logic [COUNT_W-1:0]      freed_count
);

	localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned CW = $clog2(CELLS + 1);
	localparam int unsigned LW = (CW > SIZE_W) ? CW : SIZE_W;

	logic [OWNER_BITS-1:0] mem [CELLS];

	logic [SIZE_W-1:0]     mem_size_q;
	logic                  op_q;
	logic [SIZE_W-1:0]     size_q;
	logic [OWNER_BITS-1:0] tag_q;
	logic                  skip_q;
	logic [CW-1:0]         end_q;
	logic [CW-1:0]         idx_q;
	logic                  v_s1;
	logic [AW-1:0]         addr_s1;
	logic                  last_s1;
	logic [OWNER_BITS-1:0] rdata_s1;
	logic [LW-1:0]         run_len_q;
	logic [AW-1:0]         run_start_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  found_q;
	logic [START_W-1:0]    res_start_q;

	logic [OWNER_BITS-1:0] tag_in;
	logic [LW-1:0]         limit;
	logic                  issue;
	logic                  cell_free;
	logic [LW-1:0]         new_len;
	logic [AW-1:0]         start_now;
	logic                  hit;
	logic                  match;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [OWNER_BITS-1:0] wdata;

	assign tag_in = OWNER_BITS'(owner);
	assign limit  = (LW'(mem_size_q) < LW'(CELLS)) ? LW'(mem_size_q) : LW'(CELLS);

	// Scan step: one read issued, one registered cell examined per cycle
	assign issue     = cmd.scan && !skip_q && (idx_q < end_q);
	assign cell_free = (rdata_s1 == '0);
	assign new_len   = run_len_q + LW'(1);
	assign start_now = (run_len_q == '0) ? addr_s1 : run_start_q;
	assign hit       = cmd.scan && v_s1 && (op_q == OP_ALLOC) && cell_free
		&& (new_len == LW'(size_q));
	assign match     = cmd.scan && v_s1 && (op_q == OP_FREE) && (rdata_s1 == tag_q);

	assign sts.clear_done = cmd.clear && (idx_q == CW'(CELLS - 1));
	assign sts.scan_done  = cmd.scan && (skip_q || (v_s1 && (hit || last_s1)));
	assign sts.hit        = hit;
	assign sts.fill_done  = cmd.fill && (run_len_q == LW'(1));

	// Select the single write of the cycle
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = '0;
		if (cmd.clear) begin
			we    = 1'b1;
			waddr = idx_q[AW-1:0];
		end else if (cmd.fill) begin
			we    = 1'b1;
			waddr = run_start_q;
			wdata = tag_q;
		end else if (match) begin
			we = 1'b1;
		end
	end

	// Owner tag store with registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (issue) rdata_s1 <= mem[idx_q[AW-1:0]];
	end

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= MEM_SIZE_RST;
		end else if (cfg_we) begin
			mem_size_q <= cfg_wdata;
		end
	end

	// Sweep index, read pipeline and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
		end else if (cmd.capture) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
		end else if (cmd.clear) begin
			idx_q <= idx_q + CW'(1);
		end else begin
			v_s1 <= issue;
			if (issue) idx_q <= idx_q + CW'(1);
		end
	end

	// Capture the request and advance scan and fill registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q        <= command;
			size_q      <= request_size;
			tag_q       <= tag_in;
			run_len_q   <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			res_start_q <= '0;
			if (command == OP_ALLOC) begin
				end_q  <= CW'(limit);
				skip_q <= (request_size == '0) || (tag_in == '0) || (limit == '0);
			end else begin
				end_q  <= CW'(CELLS);
				skip_q <= (tag_in == '0);
			end
		end else if (cmd.scan) begin
			if (issue) begin
				addr_s1 <= idx_q[AW-1:0];
				last_s1 <= ((idx_q + CW'(1)) == end_q);
			end
			if (hit) begin
				found_q     <= 1'b1;
				res_start_q <= START_W'(start_now);
				run_start_q <= start_now;
				run_len_q   <= LW'(size_q);
			end else if (v_s1 && (op_q == OP_ALLOC)) begin
				run_len_q   <= cell_free ? new_len : '0;
				run_start_q <= start_now;
			end
			if (match && (count_q != COUNT_MAX)) count_q <= count_q + COUNT_W'(1);
		end else if (cmd.fill) begin
			run_start_q <= run_start_q + AW'(1);
			run_len_q   <= run_len_q - LW'(1);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found       <= found_q;
			start_index <= res_start_q;
			freed_count <= count_q;
		end
	end

endmodule

`default_nettype wire

/* sv/first_fit_owner_allocator_top.sv */
`default_nettype none
// First-fit owner allocator over a store of CELLS owner tags.
// Requests arrive on req (valid/ready): command 0 allocates request_size
// consecutive free cells below the size register for owner, command 1 frees
// every cell tagged with owner. Each request gives exactly one item on rsp:
// found and start_index for an allocate, freed_count for a free.
// cfg_we/cfg_wdata write the size register (reset 1024); write it only while
// no request is in progress.
// After reset the store is swept to all-free, one cell a cycle; req.ready
// stays low meanwhile.
// A request is captured, then the cells are read from the tag memory and
// examined in turn (up to min(size register, CELLS) cells for an allocate,
// all CELLS for a free), then on a hit the run of request_size cells is
// tagged with owner, then the output register is loaded. A degenerate
// request (size or owner zero) skips the scan.
// The result sits in an output register: the next request is taken while it
// waits, and only its own hand-over waits for rsp.ready.
module first_fit_owner_allocator_top import ffoa_pkg::*; #(
	parameter int unsigned CELLS      = 1024,
	parameter int unsigned OWNER_BITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_wdata,
	ffoa_req_if.sink               req,
	ffoa_rsp_if.source             rsp
);

	ffoa_cmd_t cmd;
	ffoa_sts_t sts;

	ffoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffoa_dp #(
		.CELLS      (CELLS),
		.OWNER_BITS (OWNER_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.command      (req.command),
		.request_size (req.request_size),
		.owner        (req.owner),
		.found        (rsp.found),
		.start_index  (rsp.start_index),
		.freed_count  (rsp.freed_count)
	);

	// No request is taken during the clearing sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !req.ready)
		else $error("request accepted during clearing sweep");

	// A failed allocate or a free reports start index zero
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.start_index == '0))
		else $error("start_index non-zero without a hit");

	// A successful allocate frees nothing
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> (rsp.freed_count == '0))
		else $error("freed_count non-zero on allocate");

endmodule

`default_nettype wire

/* verif/ffoa_alloc_monitor.sv */
// Watches both channels and the size register port, keeps its own copy of the
// owner tag store and predicts one result per accepted request.
module ffoa_alloc_monitor import ffoa_pkg::*; #(
	parameter int unsigned CELLS      = 1024,
	parameter int unsigned OWNER_BITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_wdata,
	ffoa_req_if                    req,
	ffoa_rsp_if                    rsp,
	output int                     fail_count,
	output int                     outstanding
);

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] start_index;
		logic [COUNT_W-1:0] freed_count;
	} alloc_result_t;

	logic [OWNER_BITS-1:0] cell_tag [CELLS];
	logic [SIZE_W-1:0]     mem_size;
	alloc_result_t         expected_results[$];

	// Apply one request to the tag store and return the result it must give
	function automatic alloc_result_t serve_request(input logic cmd,
		input logic [SIZE_W-1:0] size, input logic [OWNER_W-1:0] owner_id);
		alloc_result_t         res;
		logic [OWNER_BITS-1:0] tag;
		int unsigned           limit, run_start, run_len, released;
		res = '0;
		tag = OWNER_BITS'(owner_id);
		if (cmd == OP_FREE) begin
			// the whole store is swept, whatever the size register says
			released = 0;
			if (tag != '0) begin
				for (int i = 0; i < CELLS; i++) begin
					if (cell_tag[i] == tag) begin
						cell_tag[i] = '0;
						if (released < COUNT_MAX)
							released++;
					end
				end
			end
			res.freed_count = released[COUNT_W-1:0];
		end else if (size != '0 && tag != '0) begin
			limit     = (mem_size < CELLS) ? mem_size : CELLS;
			run_start = 0;
			run_len   = 0;
			for (int i = 0; i < limit; i++) begin
				if (cell_tag[i] != '0) begin
					run_len = 0;
				end else begin
					if (run_len == 0)
						run_start = i;
					run_len++;
					if (run_len == size) begin
						for (int k = run_start; k <= i; k++)
							cell_tag[k] = tag;
						res.found       = 1'b1;
						res.start_index = run_start[START_W-1:0];
						break;
					end
				end
			end
		end
		return res;
	endfunction

	// Track register writes, predict on each request, check each result
	always @(posedge clk or negedge arst_n) begin : track
		alloc_result_t want;
		alloc_result_t pred;
		int            pushed, popped, errs;
		if (!arst_n) begin
			foreach (cell_tag[i])
				cell_tag[i] = '0;
			mem_size = MEM_SIZE_RST;
			expected_results.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			pushed = 0;
			popped = 0;
			errs   = 0;
			if (cfg_we)
				mem_size = cfg_wdata;
			// compare before queuing, so a result can never match its own request
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no request waiting");
					errs++;
				end else begin
					want   = expected_results.pop_front();
					popped = 1;
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, rsp.found);
						errs++;
					end
					if (rsp.start_index !== want.start_index) begin
						$error("start_index: expected %0d, actual %0d",
							want.start_index, rsp.start_index);
						errs++;
					end
					if (rsp.freed_count !== want.freed_count) begin
						$error("freed_count: expected %0d, actual %0d",
							want.freed_count, rsp.freed_count);
						errs++;
					end
				end
			end
			if (req.valid && req.ready) begin
				pred = serve_request(req.command, req.request_size, req.owner);
				expected_results.insert(expected_results.size(), pred);
				pushed = 1;
			end
			outstanding <= outstanding + pushed - popped;
			fail_count  <= fail_count + errs;
		end
	end

endmodule

/* verif/tb_first_fit_owner_allocator_top.sv */
module tb_first_fit_owner_allocator_top;
	import ffoa_pkg::*;

	localparam int unsigned CELLS          = 1024;
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam int          PHASES         = 10;
	localparam int          PHASE_ITEMS    = 54;
	localparam int          POOL           = 6;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = MEM_SIZE_RST;

	int send_idle    = 15;
	int recv_idle    = 46;
	int usable       = CELLS;
	int quiet_cycles = 0;
	int fail_count;
	int outstanding;

	ffoa_req_if req_ch();
	ffoa_rsp_if rsp_ch();

	first_fit_owner_allocator_top #(
		.CELLS      (CELLS),
		.OWNER_BITS (OWNER_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	ffoa_alloc_monitor #(
		.CELLS      (CELLS),
		.OWNER_BITS (OWNER_W)
	) u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Offer one request, with a random gap first, and hold it until taken
	task automatic send_request(input logic cmd, input int size, input int owner_id);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.request_size <= size[SIZE_W-1:0];
		req_ch.owner        <= owner_id[OWNER_W-1:0];
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Hold off new requests until every result has come back
	task automatic wait_until_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_mem_size(input int value);
		wait_until_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value[SIZE_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		usable = (value < CELLS) ? value : CELLS;
	endtask

	initial begin : stimulus
		int mem_sizes [PHASES];
		int pool [POOL];
		int pick, size, max_size, slot;
		mem_sizes = '{40, 1024, 16, 2047, 100, 1, 0, 64, 24, 1024};
		req_ch.valid        <= 1'b0;
		req_ch.command      <= OP_ALLOC;
		req_ch.request_size <= '0;
		req_ch.owner        <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: degenerate requests, whole-store runs, holes, size register corners
		send_request(OP_ALLOC, 1, 1);
		send_request(OP_ALLOC, 0, 2);
		send_request(OP_ALLOC, 5, 0);
		send_request(OP_FREE, 0, 0);
		send_request(OP_ALLOC, 1024, 3);
		send_request(OP_FREE, 2047, 1);
		send_request(OP_ALLOC, 1024, 1023);
		send_request(OP_FREE, 1, 1023);
		send_request(OP_ALLOC, 2047, 512);
		send_request(OP_ALLOC, 3, 4);
		send_request(OP_ALLOC, 2, 5);
		send_request(OP_ALLOC, 4, 4);
		send_request(OP_FREE, 0, 5);
		send_request(OP_ALLOC, 1, 6);
		send_request(OP_ALLOC, 2, 7);
		send_request(OP_FREE, 0, 4);
		write_mem_size(0);
		send_request(OP_ALLOC, 1, 1);
		write_mem_size(2047);
		send_request(OP_ALLOC, 8, 9);
		// shrink below cells that are still tagged
		write_mem_size(1);
		send_request(OP_ALLOC, 1, 8);
		send_request(OP_ALLOC, 1, 8);
		send_request(OP_FREE, 0, 7);
		send_request(OP_FREE, 0, 6);
		send_request(OP_FREE, 0, 8);
		send_request(OP_FREE, 0, 9);

		foreach (pool[k])
			pool[k] = $urandom_range(1, 1023);

		// Random phases, each under its own size register value
		for (int p = 0; p < PHASES; p++) begin
			if (p == 4) begin
				send_idle = 46;
				recv_idle = 15;
			end else if (p == 7) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_mem_size(mem_sizes[p]);
			// retire two owners so the store does not silt up
			for (int k = 0; k < 2; k++) begin
				slot = $urandom_range(POOL - 1);
				send_request(OP_FREE, $urandom_range(2047), pool[slot]);
				pool[slot] = $urandom_range(1, 1023);
			end
			max_size = (usable >= 16) ? usable / 8 : 2;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && p % 3 == 0)
					wait_until_drained();
				pick = $urandom_range(99);
				if (pick < 14) begin
					send_request(OP_FREE, $urandom_range(2047), pool[$urandom_range(POOL - 1)]);
				end else if (pick < 18) begin
					send_request(1'($urandom_range(1)), $urandom_range(2047),
						$urandom_range(1023));
				end else if (pick < 20) begin
					if ($urandom_range(1))
						send_request(OP_ALLOC, 0, pool[$urandom_range(POOL - 1)]);
					else
						send_request(OP_ALLOC, $urandom_range(1, max_size), 0);
				end else begin
					if ($urandom_range(19) == 0)
						size = $urandom_range(1, 1024);
					else
						size = $urandom_range(1, max_size);
					send_request(OP_ALLOC, size, pool[$urandom_range(POOL - 1)]);
				end
			end
		end

		wait_until_drained();
		repeat (2100) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
